// ===== hdl/hex_text_to_bytes_top_assert.svh =====
// Assertion macros shared by the checker of the hex text to bytes block.
`ifndef HEX_TEXT_TO_BYTES_TOP_ASSERT_SVH
`define HEX_TEXT_TO_BYTES_TOP_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define HEXB_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define HEXB_ASSERT_ANY(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/hexb_pkg.sv =====
// Shared types and constants of the hex text to bytes block.
package hexb_pkg;

    localparam int CHAR_W    = 8;
    localparam int COUNT_W   = 9;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 24;

    localparam logic [COUNT_W-1:0] LIMIT_MAX = 9'd256;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CHAR_UA    = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UF    = 8'h46;
    localparam logic [CHAR_W-1:0] CHAR_LA    = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LF_HEX = 8'h66;
    localparam logic [CHAR_W-1:0] CHAR_X     = 8'h78;
    localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0d;
    localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0a;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_COMMA = 8'h2c;

    localparam logic [CHAR_W-1:0] OFS_DIGIT = 8'h30;
    localparam logic [CHAR_W-1:0] OFS_UPPER = 8'h37;
    localparam logic [CHAR_W-1:0] OFS_LOWER = 8'h57;

    typedef enum logic [1:0] {
        STOP_END     = 2'd0,
        STOP_INVALID = 2'd1,
        STOP_LIMIT   = 2'd2
    } stop_t;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } char_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  byte_out;
        logic               byte_valid;
        logic               finished;
        logic [COUNT_W-1:0] byte_count;
        stop_t              stop_reason;
    } result_t;

endpackage

// ===== hdl/hexb_in_reg.sv =====
// Input register stage that captures one character transfer.
module hexb_in_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hexb_pkg::char_item_t s_item,
    input  logic                advance,
    output logic                item_valid,
    output hexb_pkg::char_item_t item
);
    import hexb_pkg::*;

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;

    assign s_ready    = !valid_reg || advance;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (s_ready) begin
            valid_next = s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

// ===== hdl/hexb_parse.sv =====
// Per-string parse state and the decode of one character into a result.
module hexb_parse (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     take,
    input  hexb_pkg::char_item_t     item,
    input  logic [hexb_pkg::COUNT_W-1:0] max_bytes,
    output hexb_pkg::result_t        result
);
    import hexb_pkg::*;

    logic               pend_reg,    pend_next;
    logic               have_hi_reg, have_hi_next;
    logic [3:0]         hi_nib_reg,  hi_nib_next;
    logic [COUNT_W-1:0] done_reg,    done_next;
    logic               halted_reg,  halted_next;
    stop_t              cause_reg,   cause_next;

    logic [COUNT_W-1:0] limit;
    logic               is_hex;
    logic               is_skip;
    logic [CHAR_W-1:0]  hex_diff;
    logic [3:0]         nib;
    logic               handle;
    logic               valid;
    logic [CHAR_W-1:0]  byte_v;

    assign limit = (max_bytes == '0 || max_bytes > LIMIT_MAX) ? LIMIT_MAX : max_bytes;

    always_comb begin
        is_hex   = 1'b1;
        hex_diff = '0;
        if (item.ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
            hex_diff = item.ch - OFS_DIGIT;
        end else if (item.ch inside {[CHAR_UA:CHAR_UF]}) begin
            hex_diff = item.ch - OFS_UPPER;
        end else if (item.ch inside {[CHAR_LA:CHAR_LF_HEX]}) begin
            hex_diff = item.ch - OFS_LOWER;
        end else begin
            is_hex = 1'b0;
        end
        nib     = hex_diff[3:0];
        is_skip = item.ch inside {CHAR_CR, CHAR_LF, CHAR_SPACE, CHAR_COMMA};
    end

    always_comb begin
        pend_next    = pend_reg;
        have_hi_next = have_hi_reg;
        hi_nib_next  = hi_nib_reg;
        done_next    = done_reg;
        halted_next  = halted_reg;
        cause_next   = cause_reg;
        handle       = 1'b1;
        valid        = 1'b0;
        byte_v       = '0;

        if (!halted_reg) begin
            // A held zero is resolved by the character that follows it.
            if (pend_reg) begin
                pend_next = 1'b0;
                if (item.ch == CHAR_X) begin
                    handle = 1'b0;
                end else if (!have_hi_next) begin
                    hi_nib_next  = 4'h0;
                    have_hi_next = 1'b1;
                end else begin
                    byte_v       = {hi_nib_next, 4'h0};
                    valid        = 1'b1;
                    have_hi_next = 1'b0;
                    done_next    = done_reg + 1'b1;
                    if (done_next >= limit) begin
                        halted_next = 1'b1;
                        cause_next  = STOP_LIMIT;
                        handle      = 1'b0;
                    end
                end
            end
            if (handle) begin
                if (item.ch == CHAR_ZERO && !item.last) begin
                    pend_next = 1'b1;
                end else if (is_hex) begin
                    if (!have_hi_next) begin
                        hi_nib_next  = nib;
                        have_hi_next = 1'b1;
                    end else begin
                        byte_v       = {hi_nib_next, nib};
                        valid        = 1'b1;
                        have_hi_next = 1'b0;
                        done_next    = done_next + 1'b1;
                        if (done_next >= limit) begin
                            halted_next = 1'b1;
                            cause_next  = STOP_LIMIT;
                        end
                    end
                end else if (is_skip) begin
                end else begin
                    halted_next = 1'b1;
                    cause_next  = STOP_INVALID;
                end
            end
        end

        result.byte_out    = byte_v;
        result.byte_valid  = valid;
        result.finished    = item.last;
        result.byte_count  = done_next;
        result.stop_reason = (item.last && halted_next) ? cause_next : STOP_END;

        if (item.last) begin
            pend_next    = 1'b0;
            have_hi_next = 1'b0;
            hi_nib_next  = 4'h0;
            done_next    = '0;
            halted_next  = 1'b0;
            cause_next   = STOP_END;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            have_hi_reg <= 1'b0;
            hi_nib_reg  <= 4'h0;
            done_reg    <= '0;
            halted_reg  <= 1'b0;
            cause_reg   <= STOP_END;
        end else if (take) begin
            pend_reg    <= pend_next;
            have_hi_reg <= have_hi_next;
            hi_nib_reg  <= hi_nib_next;
            done_reg    <= done_next;
            halted_reg  <= halted_next;
            cause_reg   <= cause_next;
        end
    end

endmodule

// ===== hdl/hexb_out_reg.sv =====
// Result register that holds one result until the receiver takes it.
module hexb_out_reg (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    input  hexb_pkg::result_t in_result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output hexb_pkg::result_t m_result
);
    import hexb_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t result_reg;

    assign advance  = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_result = result_reg;

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid) begin
            result_reg <= in_result;
        end
    end

endmodule

// ===== hdl/hex_text_to_bytes_top.sv =====
// Top level of the hex text to bytes parser.
// The block reads one text character per transfer on the s_ channel and
// returns exactly one result per character on the m_ channel. Pairs of hex
// digits are packed into bytes, the prefix "0x" and the separators CR, LF,
// space and comma are skipped, and any other character or reaching the byte
// limit stops the parse until the character marked by s_tlast.
// A character transfer is captured by the input register, which feeds the decode
// logic, which loads the result register with the result of that character. A new
// character is accepted in every cycle, so the sustained rate is one character per
// cycle with the receiver always ready.
// When the receiver stalls, the result register holds its result, the input
// register can still take one character, and s_tready then stays low until
// m_tready returns.
// The cfg_ channel writes the byte limit; a value of zero or above 256 means 256. It must
// be written by the user only while no string is in progress; the block does not enforce it.
// Reset clears both registers, the parse state and sets the limit to 256.
module hex_text_to_bytes_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [hexb_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_in
    input  logic                           s_tlast,   // last_char
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [hexb_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] byte_out, [16:8] byte_count,
                                                      // [18:17] stop_reason, [23:19] zero
    output logic                           m_tuser,   // byte_valid
    output logic                           m_tlast,   // finished
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hexb_pkg::COUNT_W-1:0]   cfg_data   // max_bytes
);
    import hexb_pkg::*;

    logic               advance;
    logic               item_valid;
    char_item_t         s_item;
    char_item_t         item;
    result_t            result;
    result_t            m_result;
    logic [COUNT_W-1:0] max_reg;

    assign s_item.ch   = s_tdata;
    assign s_item.last = s_tlast;
    assign cfg_ready   = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= LIMIT_MAX;
        end else if (cfg_valid && cfg_ready) begin
            max_reg <= cfg_data;
        end
    end

    hexb_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    hexb_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .take      (item_valid && advance),
        .item      (item),
        .max_bytes (max_reg),
        .result    (result)
    );

    hexb_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (item_valid),
        .in_result (result),
        .advance   (advance),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_result  (m_result)
    );

    assign m_tdata = {5'd0, m_result.stop_reason, m_result.byte_count, m_result.byte_out};
    assign m_tuser = m_result.byte_valid;
    assign m_tlast = m_result.finished;

endmodule

// ===== hdl/hexb_checker.sv =====
// Port-level checker of the hex text to bytes block and its bind.
`include "hex_text_to_bytes_top_assert.svh"

module hexb_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [hexb_pkg::M_TDATA_W-1:0] m_tdata,
    input logic                           m_tuser,
    input logic                           m_tlast
);
    import hexb_pkg::*;

    `HEXB_ASSERT_ANY(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")
    `HEXB_ASSERT_CLK(a_stall_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
    `HEXB_ASSERT_CLK(a_reason_last, m_tvalid && !m_tlast |-> m_tdata[18:17] == STOP_END, "stop reason before end of string")
    `HEXB_ASSERT_CLK(a_byte_zero, m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0, "byte data without a completed byte")
    `HEXB_ASSERT_CLK(a_reason_code, m_tvalid |-> m_tdata[18:17] != 2'd3, "unknown stop reason")

endmodule

bind hex_text_to_bytes_top hexb_checker u_hexb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the hex text to bytes parser, with its own decode model.
module testbench;
    import hexb_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 4;
    localparam int TAIL_CYCLES  = 12;
    localparam int REPORT_LINES = 40;
    localparam int PHASES       = 10;
    localparam int LONG_TEXT    = 130;
    localparam int PHASE_CHARS  = 22;

    typedef enum logic [1:0] {
        ITEM_CHAR,
        ITEM_LIMIT,
        ITEM_DRAIN
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [CHAR_W-1:0]  ch;
        logic               lst;
        logic [COUNT_W-1:0] limit;
    } sched_item_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [COUNT_W-1:0]   cfg_data  = '0;

    sched_item_t input_schedule[$];
    result_t     decoded_due[$];

    // Decode model state.
    logic               zero_held   = 1'b0;
    logic               nib_pending = 1'b0;
    logic [3:0]         nib_hi      = '0;
    logic [COUNT_W-1:0] count_now   = '0;
    logic               stopped     = 1'b0;
    stop_t              stop_cause  = STOP_END;
    logic [COUNT_W-1:0] limit_reg   = LIMIT_MAX;

    int burst_left     = 1;
    int gap_left       = 0;
    int settle_count   = 0;
    int cycle_count    = 0;
    int error_count    = 0;
    int results_seen   = 0;
    int total_chars    = 0;
    int total_strings  = 0;
    int total_bytes    = 0;
    int stops_invalid  = 0;
    int stops_limit    = 0;
    int limits_written = 0;
    logic [9:0] rx_tick = '0;

    hex_text_to_bytes_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_parse();
        zero_held   = 1'b0;
        nib_pending = 1'b0;
        nib_hi      = '0;
        count_now   = '0;
        stopped     = 1'b0;
        stop_cause  = STOP_END;
    endfunction

    function automatic int active_limit();
        if (limit_reg == '0 || limit_reg > LIMIT_MAX) begin
            return int'(LIMIT_MAX);
        end
        return int'(limit_reg);
    endfunction

    function automatic logic hex_value(input logic [CHAR_W-1:0] c, output logic [3:0] v);
        logic [CHAR_W-1:0] d;
        d = '0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - OFS_DIGIT;
        end else if (c >= CHAR_UA && c <= CHAR_UF) begin
            d = c - OFS_UPPER;
        end else if (c >= CHAR_LA && c <= CHAR_LF_HEX) begin
            d = c - OFS_LOWER;
        end else begin
            v = 4'h0;
            return 1'b0;
        end
        v = d[3:0];
        return 1'b1;
    endfunction

    function automatic logic feed_nibble(input logic [3:0] nib, output logic [7:0] b);
        b = 8'h00;
        if (!nib_pending) begin
            nib_hi      = nib;
            nib_pending = 1'b1;
            return 1'b0;
        end
        b           = {nib_hi, nib};
        nib_pending = 1'b0;
        count_now   = count_now + 1'b1;
        total_bytes++;
        if (int'(count_now) >= active_limit()) begin
            stopped    = 1'b1;
            stop_cause = STOP_LIMIT;
        end
        return 1'b1;
    endfunction

    function automatic result_t decode_char(input logic [CHAR_W-1:0] c, input logic lst);
        result_t    r;
        logic       handle;
        logic [3:0] v;
        logic [7:0] b;
        r = '0;
        total_chars++;
        if (!stopped) begin
            handle = 1'b1;
            // A held zero is either the start of the prefix or a plain digit.
            if (zero_held) begin
                zero_held = 1'b0;
                if (c == CHAR_X) begin
                    handle = 1'b0;
                end else begin
                    r.byte_valid = feed_nibble(4'h0, b);
                    r.byte_out   = b;
                    if (stopped) begin
                        handle = 1'b0;
                    end
                end
            end
            if (handle) begin
                if (c == CHAR_ZERO && !lst) begin
                    zero_held = 1'b1;
                end else if (hex_value(c, v)) begin
                    if (feed_nibble(v, b)) begin
                        r.byte_valid = 1'b1;
                        r.byte_out   = b;
                    end
                end else if (!(c == CHAR_CR || c == CHAR_LF || c == CHAR_SPACE ||
                               c == CHAR_COMMA)) begin
                    stopped    = 1'b1;
                    stop_cause = STOP_INVALID;
                end
            end
        end
        r.finished    = lst;
        r.byte_count  = count_now;
        r.stop_reason = (lst && stopped) ? stop_cause : STOP_END;
        if (lst) begin
            total_strings++;
            if (r.stop_reason == STOP_INVALID) begin
                stops_invalid++;
            end
            if (r.stop_reason == STOP_LIMIT) begin
                stops_limit++;
            end
            clear_parse();
        end
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        error_count++;
        if (error_count <= REPORT_LINES) begin
            $display("mismatch in %s at result %0d: got 0x%0h, expected 0x%0h",
                     what, results_seen, got, want);
        end
    endtask

    function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CHAR_ZERO + v;
        end
        if ($urandom_range(0, 1) != 0) begin
            return CHAR_LA + v - 8'd10;
        end
        return CHAR_UA + v - 8'd10;
    endfunction

    task automatic queue_char(input logic [CHAR_W-1:0] c, input logic lst);
        sched_item_t it;
        it.kind  = ITEM_CHAR;
        it.ch    = c;
        it.lst   = lst;
        it.limit = '0;
        input_schedule.push_back(it);
    endtask

    task automatic queue_control(input item_kind_t kind, input logic [COUNT_W-1:0] value);
        sched_item_t it;
        it.kind  = kind;
        it.ch    = '0;
        it.lst   = 1'b0;
        it.limit = value;
        input_schedule.push_back(it);
    endtask

    task automatic queue_text(input string s, input bit ends);
        int i;
        for (i = 0; i < s.len(); i++) begin
            queue_char(s[i], ends && (i == s.len() - 1));
        end
    endtask

    task automatic queue_random_string(input int len, input bit noisy);
        logic [CHAR_W-1:0] text[$];
        logic [CHAR_W-1:0] sep;
        int                pick;
        int                i;
        while (text.size() < len) begin
            pick = $urandom_range(0, noisy ? 99 : 79);
            if (pick < 50) begin
                text.push_back(hex_char(4'($urandom_range(0, 15))));
            end else if (pick < 62) begin
                text.push_back(CHAR_ZERO);
            end else if (pick < 70) begin
                text.push_back(CHAR_ZERO);
                text.push_back(CHAR_X);
            end else if (pick < 80) begin
                case ($urandom_range(0, 3))
                    0: sep = CHAR_CR;
                    1: sep = CHAR_LF;
                    2: sep = CHAR_SPACE;
                    default: sep = CHAR_COMMA;
                endcase
                text.push_back(sep);
            end else if (pick < 88) begin
                text.push_back(($urandom_range(0, 1) != 0) ? CHAR_X : "X");
            end else begin
                text.push_back(8'($urandom_range(0, 255)));
            end
        end
        for (i = 0; i < len; i++) begin
            queue_char(text[i], i == len - 1);
        end
    endtask

    always @(posedge aclk) begin : drive_proc
        logic        next_valid;
        logic        next_cfg;
        sched_item_t head;
        next_valid = s_tvalid;
        next_cfg   = cfg_valid;
        if (!aresetn) begin
            next_valid = 1'b0;
            next_cfg   = 1'b0;
            clear_parse();
            limit_reg    = LIMIT_MAX;
            burst_left   = 1;
            gap_left     = 0;
            settle_count = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                decoded_due.push_back(decode_char(s_tdata, s_tlast));
                next_valid = 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                limit_reg = cfg_data;
                limits_written++;
                next_cfg = 1'b0;
            end
            if (decoded_due.size() == 0 && !next_valid && !next_cfg) begin
                settle_count++;
            end else begin
                settle_count = 0;
            end
            if (!next_valid && !next_cfg && input_schedule.size() != 0) begin
                head = input_schedule[0];
                if (head.kind == ITEM_CHAR) begin
                    if (gap_left > 0) begin
                        gap_left--;
                    end else begin
                        head       = input_schedule.pop_front();
                        next_valid = 1'b1;
                        s_tdata   <= head.ch;
                        s_tlast   <= head.lst;
                        burst_left--;
                        if (burst_left <= 0) begin
                            burst_left = $urandom_range(1, 24);
                            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                        end
                    end
                end else if (settle_count >= SETTLE_WAIT) begin
                    // Limit writes and pauses only go ahead once every result is back.
                    head = input_schedule.pop_front();
                    if (head.kind == ITEM_LIMIT) begin
                        next_cfg  = 1'b1;
                        cfg_data <= head.limit;
                    end
                end
            end
        end
        s_tvalid  <= next_valid;
        cfg_valid <= next_cfg;
    end

    always @(posedge aclk) begin : check_proc
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_tick  <= '0;
        end else begin
            rx_tick <= rx_tick + 1'b1;
            case (rx_tick[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: m_tready <= (rx_tick[2:0] != 3'd6) && (rx_tick[5:3] != 3'd2);
                default: m_tready <= ($urandom_range(0, 1) != 0);
            endcase
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (decoded_due.size() == 0) begin
                    report_mismatch("unexpected result", int'(m_tdata), 0);
                end else begin
                    want = decoded_due.pop_front();
                    if (m_tdata[7:0] != want.byte_out) begin
                        report_mismatch("byte_out", int'(m_tdata[7:0]), int'(want.byte_out));
                    end
                    if (m_tuser != want.byte_valid) begin
                        report_mismatch("byte_valid", int'(m_tuser), int'(want.byte_valid));
                    end
                    if (m_tlast != want.finished) begin
                        report_mismatch("finished", int'(m_tlast), int'(want.finished));
                    end
                    if (m_tdata[16:8] != want.byte_count) begin
                        report_mismatch("byte_count", int'(m_tdata[16:8]),
                                        int'(want.byte_count));
                    end
                    if (m_tdata[18:17] != want.stop_reason) begin
                        report_mismatch("stop_reason", int'(m_tdata[18:17]),
                                        int'(want.stop_reason));
                    end
                    if (m_tdata[23:19] != '0) begin
                        report_mismatch("tdata padding", int'(m_tdata[23:19]), 0);
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles with %0d results outstanding",
                     cycle_count, decoded_due.size());
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial begin : run_proc
        int                 p;
        int                 i;
        int                 n;
        int                 chars_in_phase;
        logic [COUNT_W-1:0] lim;
        logic [COUNT_W-1:0] phase_limits[8];

        phase_limits = '{9'd3, 9'd511, 9'd0, 9'd256, 9'd2, 9'd300, 9'd17, 9'd1};

        // Directed strings: prefix, separators, held zeros, a zero at the end,
        // bad characters, a dropped odd nibble and the byte limit.
        queue_text("0x9F", 1'b1);
        queue_text("a0,", 1'b0);
        queue_char(CHAR_CR, 1'b0);
        queue_char(CHAR_LF, 1'b0);
        queue_text(" f0", 1'b1);
        queue_char(CHAR_UA, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_text("1", 1'b1);
        queue_char(8'h00, 1'b1);
        queue_text("e", 1'b1);
        queue_control(ITEM_LIMIT, 9'd1);
        queue_text("B07", 1'b1);
        queue_text("12", 1'b1);

        for (p = 0; p < PHASES; p++) begin
            lim = (p < 8) ? phase_limits[p] : 9'($urandom_range(1, 256));
            queue_control(ITEM_LIMIT, lim);
            if (lim == 9'd511) begin
                // A long run of dense digits under the widest limit.
                for (i = 0; i < LONG_TEXT; i++) begin
                    queue_char(hex_char(4'($urandom_range(0, 15))), i == LONG_TEXT - 1);
                end
            end
            chars_in_phase = 0;
            while (chars_in_phase < PHASE_CHARS) begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 16);
                queue_random_string(n, $urandom_range(0, 9) < 3);
                chars_in_phase += n;
                if (p == 3 && chars_in_phase < PHASE_CHARS &&
                    chars_in_phase >= PHASE_CHARS / 2) begin
                    queue_control(ITEM_DRAIN, '0);
                end
            end
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (input_schedule.size() != 0 || s_tvalid || cfg_valid) @(negedge aclk);
        while (decoded_due.size() != 0) @(negedge aclk);
        repeat (TAIL_CYCLES) @(negedge aclk);

        $display("checked %0d characters in %0d strings over %0d limit settings",
                 total_chars, total_strings, limits_written);
        $display("%0d bytes decoded, %0d strings stopped by bad characters, %0d by the limit",
                 total_bytes, stops_invalid, stops_limit);
        if (error_count == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/hexb_pkg.sv
hdl/hexb_in_reg.sv
hdl/hexb_parse.sv
hdl/hexb_out_reg.sv
hdl/hex_text_to_bytes_top.sv
hdl/hexb_checker.sv
tb/sv/testbench.sv
